FILE: rtl/hms_pkg.sv
// ----------------------------------------------------------------------------
// hms_pkg
// Shared types and byte constants for the HTML markup skipper.
// ----------------------------------------------------------------------------
`default_nettype none

package hms_pkg;

    // Scan modes of the markup tracker
    typedef enum logic [2:0] {
        MODE_TEXT  = 3'd0,  // plain document text
        MODE_OPEN  = 3'd1,  // just after '<'
        MODE_DASH  = 3'd2,  // matching a hyphen of the comment prefix
        MODE_TAG   = 3'd3,  // ordinary tag body
        MODE_QUOTE = 3'd4,  // quoted text inside a tag
        MODE_CMT   = 3'd5,  // comment body
        MODE_HYPH  = 3'd6,  // run of hyphens inside a comment
        MODE_WS    = 3'd7   // whitespace after a hyphen run
    } t_scan_mode;

    // Byte codes the tracker reacts to
    localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
    localparam logic [7:0] CH_BANG   = 8'h21;  // '!'
    localparam logic [7:0] CH_HYPHEN = 8'h2D;  // '-'
    localparam logic [7:0] CH_DQUOTE = 8'h22;  // '"'
    localparam logic [7:0] CH_SQUOTE = 8'h27;  // '\''
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;  // first of the TAB..CR range
    localparam logic [7:0] CH_CR     = 8'h0D;  // last of the TAB..CR range

    // Input transaction payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // Output transaction payload
    typedef struct packed {
        logic [7:0] echo_byte;
        logic       is_markup;
        logic       is_comment;
        logic       markup_end;
        logic       doc_end;
    } t_out_item;

    // Tracker state
    typedef struct packed {
        t_scan_mode mode;
        logic       quote_is_double;
    } t_scan_state;

    // Whitespace: space, TAB, LF, VT, FF, CR
    function automatic logic is_ws(input logic [7:0] b);
        is_ws = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hms_stream_if.sv
// ----------------------------------------------------------------------------
// hms_stream_if
// Valid/ready channels for byte input and classified byte output.
// ----------------------------------------------------------------------------
`default_nettype none

interface hms_in_if;
    logic               valid;
    logic               ready;
    hms_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface hms_out_if;
    logic               valid;
    logic               ready;
    hms_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/hms_classify.sv
// ----------------------------------------------------------------------------
// hms_classify
// Next-state and flag logic: classifies one byte against the current mode.
// ----------------------------------------------------------------------------
`default_nettype none

module hms_classify (
    input  wire hms_pkg::t_scan_state i_state,
    input  wire hms_pkg::t_in_item    i_item,
    output hms_pkg::t_scan_state      o_state,
    output hms_pkg::t_out_item        o_item
);
    import hms_pkg::*;

    logic [7:0]  b;
    logic        markup;
    logic        comment;
    logic        close;
    logic        b_quote;
    logic [7:0]  close_quote;
    t_scan_state tag_nxt;   // state after ordinary unquoted tag content
    logic        tag_close;
    t_scan_state nxt;

    assign b       = i_item.data_byte;
    assign b_quote = (b == CH_DQUOTE) || (b == CH_SQUOTE);
    assign close_quote = i_state.quote_is_double ? CH_DQUOTE : CH_SQUOTE;

    // Unquoted tag content: a quote opens quoted text, '>' closes the tag
    always_comb begin
        tag_close = 1'b0;
        if (b_quote) begin
            tag_nxt.mode            = MODE_QUOTE;
            tag_nxt.quote_is_double = (b == CH_DQUOTE);
        end else if (b == CH_GT) begin
            tag_nxt.mode            = MODE_TEXT;
            tag_nxt.quote_is_double = 1'b0;
            tag_close               = 1'b1;
        end else begin
            tag_nxt.mode            = MODE_TAG;
            tag_nxt.quote_is_double = 1'b0;
        end
    end

    // Mode transitions and flags
    always_comb begin
        nxt     = i_state;
        markup  = 1'b1;
        comment = 1'b0;
        close   = 1'b0;
        case (i_state.mode)
            MODE_TEXT: begin
                if (b == CH_LT) begin
                    nxt.mode            = MODE_OPEN;
                    nxt.quote_is_double = 1'b0;
                end else begin
                    markup = 1'b0;
                end
            end
            MODE_OPEN: begin
                if (b == CH_BANG) begin
                    nxt.mode            = MODE_DASH;
                    nxt.quote_is_double = 1'b0;
                end else begin
                    nxt   = tag_nxt;
                    close = tag_close;
                end
            end
            MODE_DASH: begin
                // quote_is_double counts the prefix hyphens seen so far
                if (b == CH_HYPHEN) begin
                    if (i_state.quote_is_double) begin
                        nxt.mode            = MODE_CMT;
                        nxt.quote_is_double = 1'b0;
                    end else begin
                        nxt.quote_is_double = 1'b1;
                    end
                end else begin
                    nxt   = tag_nxt;
                    close = tag_close;
                end
            end
            MODE_TAG: begin
                nxt   = tag_nxt;
                close = tag_close;
            end
            MODE_QUOTE: begin
                if (b == close_quote) begin
                    nxt.mode            = MODE_TAG;
                    nxt.quote_is_double = 1'b0;
                end
            end
            MODE_CMT: begin
                comment = 1'b1;
                if (b == CH_HYPHEN) begin
                    nxt.mode = MODE_HYPH;
                end
            end
            MODE_HYPH: begin
                comment = 1'b1;
                if (b == CH_HYPHEN) begin
                    nxt.mode = MODE_HYPH;
                end else if (is_ws(b)) begin
                    nxt.mode = MODE_WS;
                end else if (b == CH_GT) begin
                    nxt.mode = MODE_TEXT;
                    close    = 1'b1;
                end else begin
                    nxt.mode = MODE_CMT;
                end
            end
            MODE_WS: begin
                comment = 1'b1;
                if (is_ws(b)) begin
                    nxt.mode = MODE_WS;
                end else if (b == CH_GT) begin
                    nxt.mode = MODE_TEXT;
                    close    = 1'b1;
                end else begin
                    nxt.mode = MODE_CMT;
                end
            end
            default: begin
                nxt.mode            = MODE_TEXT;
                nxt.quote_is_double = 1'b0;
            end
        endcase
    end

    // End of document drops whatever was open
    always_comb begin
        if (i_item.last_byte) begin
            o_state.mode            = MODE_TEXT;
            o_state.quote_is_double = 1'b0;
        end else begin
            o_state = nxt;
        end
    end

    assign o_item.echo_byte  = b;
    assign o_item.is_markup  = markup;
    assign o_item.is_comment = comment;
    assign o_item.markup_end = close;
    assign o_item.doc_end    = i_item.last_byte;

endmodule

`default_nettype wire

FILE: rtl/hms_out_buf.sv
// ----------------------------------------------------------------------------
// hms_out_buf
// Result register plus one skid entry, so a stalled output does not stop
// the input side until both entries are full.
// ----------------------------------------------------------------------------
`default_nettype none

module hms_out_buf (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  wire hms_pkg::t_out_item i_item,
    output logic                    o_full,
    hms_out_if.source               o_out
);
    import hms_pkg::*;

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_item r_out_item;
    t_out_item r_skid_item;
    logic      out_free;

    assign out_free = !r_out_valid || o_out.ready;

    // Control: valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_free) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (out_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out_item <= r_skid_item;
            end
        end else if (i_push) begin
            if (out_free) begin
                r_out_item <= i_item;
            end else begin
                r_skid_item <= i_item;
            end
        end
    end

    assign o_full        = r_skid_valid;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

endmodule

`default_nettype wire

FILE: rtl/html_markup_skipper_top.sv
// ----------------------------------------------------------------------------
// html_markup_skipper_top
// Streams an HTML document byte by byte and tags each byte as text, markup
// or comment.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while the skid entry is empty, and each
// yields exactly one output transaction. The only loop is the scan-mode
// register, updated by a few byte compares per cycle. Results go through an
// output register backed by one skid entry, so input ready depends only on
// that skid entry and stays high while a single result waits. Asserting
// last_byte returns the tracker to text mode after that byte.
`default_nettype none

module html_markup_skipper_top (
    input  wire       i_clk,
    input  wire       i_rst_n,
    hms_in_if.sink    i_in,
    hms_out_if.source o_out
);
    import hms_pkg::*;

    t_scan_state r_state;
    t_scan_state n_state;
    t_out_item   result;
    logic        buf_full;
    logic        in_acc;

    assign i_in.ready = !buf_full;
    assign in_acc     = i_in.valid && !buf_full;

    // Per-byte classification
    hms_classify u_classify (
        .i_state (r_state),
        .i_item  (i_in.payload),
        .o_state (n_state),
        .o_item  (result)
    );

    // Scan state register, advanced once per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode            <= MODE_TEXT;
            r_state.quote_is_double <= 1'b0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // Result register and skid entry
    hms_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_acc),
        .i_item  (result),
        .o_full  (buf_full),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    // Document end always leaves the tracker in text mode
    a_last_to_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.payload.last_byte
        |=> r_state.mode == MODE_TEXT && !r_state.quote_is_double)
        else $error("tracker not in text mode after document end");

    // Quote flag only carries meaning in quote and prefix modes
    a_qd_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.quote_is_double
        |-> r_state.mode == MODE_QUOTE || r_state.mode == MODE_DASH)
        else $error("quote flag set outside quote or prefix mode");

    // Comment bytes are markup
    a_cmt_markup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.is_comment |-> o_out.payload.is_markup)
        else $error("comment byte not flagged as markup");

    // Closing byte is markup
    a_end_markup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload.markup_end |-> o_out.payload.is_markup)
        else $error("closing byte not flagged as markup");

    // A closing byte returns the tracker to text mode
    a_end_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && result.markup_end |=> r_state.mode == MODE_TEXT)
        else $error("tracker not in text mode after a closing byte");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_html_markup_skipper_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_html_markup_skipper_top
// Streams short HTML documents into the markup skipper and checks every
// classified byte against a cycle-free model of the scan-mode tracker. A
// directed opening covers the comment and tag corner cases. Random documents
// built from text, tags, comments, broken comment openers and noise follow.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_html_markup_skipper_top;

    import hms_pkg::*;

    typedef logic [7:0] t_byte;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hms_in_if  byte_in ();
    hms_out_if byte_out ();

    html_markup_skipper_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_in),
        .o_out   (byte_out)
    );

    always #6 clk = ~clk;

    // Document bytes waiting to be sent, and classifications still owed
    t_in_item  doc_bytes_q[$];
    t_out_item expected_marks[$];
    t_byte     doc_buf[$];

    int   total_bytes;
    int   bytes_accepted = 0;
    int   err_count      = 0;
    logic byte_taken     = 1'b0;

    // Tracker copy used for prediction
    t_scan_mode trk_mode     = MODE_TEXT;
    logic       trk_quote_dq = 1'b0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic is_blank(input t_byte b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    // Ordinary tag content; returns 1 when the byte closes the tag
    function automatic logic tag_body_byte(input t_byte b);
        if (trk_mode == MODE_QUOTE) begin
            if (b == (trk_quote_dq ? CH_DQUOTE : CH_SQUOTE)) begin
                trk_mode     = MODE_TAG;
                trk_quote_dq = 1'b0;
            end
            return 1'b0;
        end
        if ((b == CH_DQUOTE) || (b == CH_SQUOTE)) begin
            trk_mode     = MODE_QUOTE;
            trk_quote_dq = (b == CH_DQUOTE);
            return 1'b0;
        end
        trk_quote_dq = 1'b0;
        if (b == CH_GT) begin
            trk_mode = MODE_TEXT;
            return 1'b1;
        end
        trk_mode = MODE_TAG;
        return 1'b0;
    endfunction

    function automatic t_out_item classify_byte(input t_in_item it);
        t_out_item r;
        t_byte     b;
        b            = it.data_byte;
        r.echo_byte  = b;
        r.is_markup  = 1'b1;
        r.is_comment = 1'b0;
        r.markup_end = 1'b0;
        r.doc_end    = it.last_byte;
        case (trk_mode)
            MODE_TEXT: begin
                if (b == CH_LT) begin
                    trk_mode     = MODE_OPEN;
                    trk_quote_dq = 1'b0;
                end else begin
                    r.is_markup = 1'b0;
                end
            end
            MODE_OPEN: begin
                if (b == CH_BANG) begin
                    trk_mode     = MODE_DASH;
                    trk_quote_dq = 1'b0;
                end else begin
                    r.markup_end = tag_body_byte(b);
                end
            end
            MODE_DASH: begin
                // second-hyphen flag rides on the quote bit here
                if (b == CH_HYPHEN) begin
                    if (trk_quote_dq) begin
                        trk_mode     = MODE_CMT;
                        trk_quote_dq = 1'b0;
                    end else begin
                        trk_quote_dq = 1'b1;
                    end
                end else begin
                    trk_mode     = MODE_TAG;
                    trk_quote_dq = 1'b0;
                    r.markup_end = tag_body_byte(b);
                end
            end
            MODE_TAG, MODE_QUOTE: begin
                r.markup_end = tag_body_byte(b);
            end
            MODE_CMT: begin
                r.is_comment = 1'b1;
                if (b == CH_HYPHEN) trk_mode = MODE_HYPH;
            end
            MODE_HYPH: begin
                r.is_comment = 1'b1;
                if (b == CH_HYPHEN) begin
                    trk_mode = MODE_HYPH;
                end else if (is_blank(b)) begin
                    trk_mode = MODE_WS;
                end else if (b == CH_GT) begin
                    trk_mode     = MODE_TEXT;
                    r.markup_end = 1'b1;
                end else begin
                    trk_mode = MODE_CMT;
                end
            end
            default: begin
                // whitespace after a hyphen run: a hyphen here is just consumed
                r.is_comment = 1'b1;
                if (is_blank(b)) begin
                    trk_mode = MODE_WS;
                end else if (b == CH_GT) begin
                    trk_mode     = MODE_TEXT;
                    r.markup_end = 1'b1;
                end else begin
                    trk_mode = MODE_CMT;
                end
            end
        endcase
        if (it.last_byte) begin
            trk_mode     = MODE_TEXT;
            trk_quote_dq = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic queue_byte(input t_byte b, input logic last);
        t_in_item it;
        it.data_byte = b;
        it.last_byte = last;
        doc_bytes_q = {doc_bytes_q, it};
    endtask

    // Append one byte to the document under construction
    task automatic add_byte(input t_byte b);
        doc_buf = {doc_buf, b};
    endtask

    task automatic queue_text(input string s, input logic last);
        for (int i = 0; i < s.len(); i++)
            queue_byte(t_byte'(s[i]), last && (i == s.len() - 1));
    endtask

    function automatic t_byte ws_char();
        if ($urandom_range(0, 5) == 0) return CH_SPACE;
        return t_byte'(CH_TAB + $urandom_range(0, 4));
    endfunction

    function automatic t_byte letter_char();
        return t_byte'(8'h61 + $urandom_range(0, 25));
    endfunction

    // Bytes the tracker reacts to, or any byte at all
    function automatic t_byte special_char();
        case ($urandom_range(0, 9))
            0:       return CH_LT;
            1:       return CH_GT;
            2:       return CH_BANG;
            3:       return CH_HYPHEN;
            4:       return CH_DQUOTE;
            5:       return CH_SQUOTE;
            6:       return ws_char();
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_text();
        repeat ($urandom_range(1, 6)) add_byte(t_byte'($urandom_range(0, 255)));
    endtask

    task automatic add_tag();
        t_byte q;
        add_byte(CH_LT);
        if ($urandom_range(0, 7) == 0) add_byte(8'h2F);
        repeat ($urandom_range(1, 4)) add_byte(letter_char());
        repeat ($urandom_range(0, 3)) begin
            add_byte(ws_char());
            repeat ($urandom_range(1, 3)) add_byte(letter_char());
            add_byte(8'h3D);
            case ($urandom_range(0, 2))
                0:       q = CH_DQUOTE;
                1:       q = CH_SQUOTE;
                default: q = 8'h00;
            endcase
            if (q == 8'h00) begin
                repeat ($urandom_range(1, 3)) add_byte(letter_char());
            end else begin
                add_byte(q);
                repeat ($urandom_range(0, 5)) add_byte(special_char());
                add_byte(q);
            end
        end
        add_byte(CH_GT);
    endtask

    task automatic add_comment();
        int pick;
        add_byte(CH_LT);
        add_byte(CH_BANG);
        add_byte(CH_HYPHEN);
        add_byte(CH_HYPHEN);
        repeat ($urandom_range(0, 10)) begin
            pick = $urandom_range(0, 19);
            if (pick < 6)       add_byte(CH_HYPHEN);
            else if (pick < 9)  add_byte(ws_char());
            else if (pick < 11) add_byte(CH_GT);
            else if (pick < 15) add_byte(letter_char());
            else                add_byte(t_byte'($urandom_range(0, 255)));
        end
        // closing run, optional whitespace, then '>'
        repeat ($urandom_range(1, 3)) add_byte(CH_HYPHEN);
        repeat ($urandom_range(0, 2)) add_byte(ws_char());
        add_byte(CH_GT);
    endtask

    task automatic add_broken_opener();
        add_byte(CH_LT);
        add_byte(CH_BANG);
        if ($urandom_range(0, 1)) add_byte(CH_HYPHEN);
        add_byte(special_char());
        repeat ($urandom_range(0, 3)) add_byte(letter_char());
        add_byte(CH_GT);
    endtask

    task automatic add_document();
        int pick;
        int cut;
        doc_buf.delete();
        repeat ($urandom_range(1, 8)) begin
            pick = $urandom_range(0, 10);
            if (pick < 3)       add_text();
            else if (pick < 6)  add_tag();
            else if (pick < 9)  add_comment();
            else if (pick < 10) add_broken_opener();
            else repeat ($urandom_range(1, 6)) add_byte(special_char());
        end
        // some documents end in the middle of a construct
        cut = doc_buf.size();
        if ($urandom_range(0, 5) == 0) cut = $urandom_range(1, doc_buf.size());
        for (int i = 0; i < cut; i++) queue_byte(doc_buf[i], i == cut - 1);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: bursts of transactions with random gaps
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk) begin
        if (rst_n) begin
            if (!byte_in.valid || byte_taken) begin
                if ((gap_left != 0) || (doc_bytes_q.size() == 0)) begin
                    byte_in.valid <= 1'b0;
                    if (gap_left != 0) gap_left = gap_left - 1;
                end else begin
                    byte_in.payload <= doc_bytes_q.pop_front();
                    byte_in.valid   <= 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(40, 120);
                        else                           burst_left = $urandom_range(1, 10);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output stall pattern, reloaded after each pass through its 16 bits
    // ------------------------------------------------------------------------
    logic [15:0] stall_pat = '1;
    int          stall_idx = 0;

    always @(negedge clk) begin
        if (rst_n) begin
            if (stall_idx == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pat = '1;
                    1:       stall_pat = 16'($urandom);
                    2:       stall_pat = 16'($urandom & $urandom) | 16'h0001;
                    default: stall_pat = 16'($urandom | $urandom);
                endcase
            end
            byte_out.ready <= stall_pat[stall_idx];
            stall_idx = (stall_idx + 1) % 16;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check results first, then predict the byte taken this edge
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_out_item want;
        t_out_item got;
        if (rst_n) begin
            if (byte_out.valid && byte_out.ready) begin
                got = byte_out.payload;
                if (expected_marks.size() == 0) begin
                    $error("result with nothing outstanding: echo_byte %02h", got.echo_byte);
                    err_count++;
                end else begin
                    want = expected_marks.pop_front();
                    if (got.echo_byte !== want.echo_byte) begin
                        $error("echo_byte: expected %02h, got %02h",
                               want.echo_byte, got.echo_byte);
                        err_count++;
                    end
                    if (got.is_markup !== want.is_markup) begin
                        $error("is_markup: expected %0b, got %0b (byte %02h)",
                               want.is_markup, got.is_markup, want.echo_byte);
                        err_count++;
                    end
                    if (got.is_comment !== want.is_comment) begin
                        $error("is_comment: expected %0b, got %0b (byte %02h)",
                               want.is_comment, got.is_comment, want.echo_byte);
                        err_count++;
                    end
                    if (got.markup_end !== want.markup_end) begin
                        $error("markup_end: expected %0b, got %0b (byte %02h)",
                               want.markup_end, got.markup_end, want.echo_byte);
                        err_count++;
                    end
                    if (got.doc_end !== want.doc_end) begin
                        $error("doc_end: expected %0b, got %0b (byte %02h)",
                               want.doc_end, got.doc_end, want.echo_byte);
                        err_count++;
                    end
                end
            end
            if (byte_in.valid && byte_in.ready) begin
                expected_marks = {expected_marks, classify_byte(byte_in.payload)};
                bytes_accepted <= bytes_accepted + 1;
                byte_taken     <= 1'b1;
            end else begin
                byte_taken <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed documents, random documents, drain
    // ------------------------------------------------------------------------
    initial begin
        int drain;
        byte_in.valid   = 1'b0;
        byte_in.payload = '0;
        byte_out.ready  = 1'b0;

        // early '>' is comment, whitespace after a run, then hyphen consumed
        queue_text("<!-->- -->", 1'b0);
        queue_byte(8'h00, 1'b0);
        // opener fails on a quote; quoted '>' is hidden
        queue_text("<!-'>'>", 1'b0);
        // opener fails on '>' which closes the tag
        queue_text("<!>", 1'b0);
        queue_text("<x\">\">", 1'b0);
        // document ends inside quotes; next byte is text again
        queue_text("<'", 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(CH_GT, 1'b1);

        while (doc_bytes_q.size() < 1320) add_document();
        total_bytes = doc_bytes_q.size();

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        while (bytes_accepted < total_bytes) @(negedge clk);
        drain = 0;
        while ((expected_marks.size() != 0) && (drain < 2000)) begin
            @(negedge clk);
            drain++;
        end
        if (expected_marks.size() != 0) begin
            $error("%0d results never arrived", expected_marks.size());
            err_count++;
        end
        repeat (10) @(negedge clk);

        if (err_count == 0)
            $display("tb_html_markup_skipper_top: clean");
        else
            $display("tb_html_markup_skipper_top: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb_html_markup_skipper_top: errors");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/hms_pkg.sv
rtl/hms_stream_if.sv
rtl/hms_classify.sv
rtl/hms_out_buf.sv
rtl/html_markup_skipper_top.sv
tb/tb_html_markup_skipper_top.sv
